// ----- design/bbcd_pkg.sv -----
package bbcd_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int CFG_BITS = 7;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_SEL_BITS = 2;

   localparam logic [CFG_BITS-1:0] CALIBRATION_LENGTH_RESET = CFG_BITS'(120);
   localparam logic [CFG_BITS-1:0] TOGGLE_PERIOD_RESET = CFG_BITS'(20);
   localparam logic STAY_ON_RESET = 1'b1;

   localparam logic [REG_SEL_BITS-1:0] REG_CALIBRATION_LENGTH = 2'd0;
   localparam logic [REG_SEL_BITS-1:0] REG_TOGGLE_PERIOD = 2'd1;
   localparam logic [REG_SEL_BITS-1:0] REG_STAY_ON = 2'd2;

   typedef enum logic [1:0] {
      KIND_CHECK = 2'd0,
      KIND_START = 2'd1,
      KIND_RUN = 2'd2,
      KIND_STOP = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_NOT_CALIBRATED = 2'd1,
      STATUS_NOT_RUNNING = 2'd2,
      STATUS_BUSY = 2'd3
   } status_type;

   typedef struct packed {
      kind_type kind;
      logic [SAMPLE_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic laser_drive;
      logic running;
      logic calibrated;
      logic calibrating;
      logic beam_cut;
      logic inconclusive;
      status_type status;
   } rsp_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] calibration_length;
      logic [CFG_BITS-1:0] toggle_period;
      logic stay_on;
   } cfg_type;

endpackage

// ----- design/beam_barrier_calibrate_detect.sv -----
// the response is registered; it waits in the skid entry while the output register is stalled
// throughput: one request per cycle while no skid entry is held; a toggle_period write stalls requests
//    while the sample count is reduced modulo the new period, one bit per cycle
// reset (synchronous, active high): laser off, not running, not calibrated, no
//    calibration extremes, registers at 120 / 20 / stay on, output and skid empty
module beam_barrier_calibrate_detect (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input bbcd_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output bbcd_pkg::rsp_type rsp_data,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [bbcd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [bbcd_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [bbcd_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic csr_pready
);

   localparam int CB = bbcd_pkg::CFG_BITS;
   localparam int DB = bbcd_pkg::CSR_DATA_BITS;

   logic [CB-1:0] cal_length_ff;
   logic [CB-1:0] period_ff;
   logic stay_on_ff;
   bbcd_pkg::cfg_type cfg;

   logic csr_write;
   logic [bbcd_pkg::REG_SEL_BITS-1:0] reg_sel;
   logic period_load;

   logic accept;
   logic core_busy;
   bbcd_pkg::rsp_type core_result;

   logic rsp_valid_ff, rsp_valid_in;
   bbcd_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic skid_valid_ff, skid_valid_in;
   bbcd_pkg::rsp_type skid_data_ff, skid_data_in;
   logic out_free;

   // register file
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel = csr_paddr[bbcd_pkg::CSR_ADDR_BITS-1:2];
   assign period_load = csr_write && reg_sel == bbcd_pkg::REG_TOGGLE_PERIOD;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_length_ff <= bbcd_pkg::CALIBRATION_LENGTH_RESET;
         period_ff <= bbcd_pkg::TOGGLE_PERIOD_RESET;
         stay_on_ff <= bbcd_pkg::STAY_ON_RESET;
      end else if (csr_write) begin
         case (reg_sel)
            bbcd_pkg::REG_CALIBRATION_LENGTH: cal_length_ff <= csr_pwdata[CB-1:0];
            bbcd_pkg::REG_TOGGLE_PERIOD: period_ff <= csr_pwdata[CB-1:0];
            bbcd_pkg::REG_STAY_ON: stay_on_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         bbcd_pkg::REG_CALIBRATION_LENGTH: csr_prdata = DB'(cal_length_ff);
         bbcd_pkg::REG_TOGGLE_PERIOD: csr_prdata = DB'(period_ff);
         bbcd_pkg::REG_STAY_ON: csr_prdata = DB'(stay_on_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign cfg.calibration_length = cal_length_ff;
   assign cfg.toggle_period = period_ff;
   assign cfg.stay_on = stay_on_ff;

   // request side
   assign req_stall = skid_valid_ff || core_busy || period_load;
   assign accept = req_valid && !req_stall;

   bbcd_core u_core (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req(req_data),
      .cfg(cfg),
      .period_load(period_load),
      .busy(core_busy),
      .result(core_result)
   );

   // output register with skid entry
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in = core_result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in = core_result;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held with empty output register");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_valid_ff && rsp_stall) |=> (skid_valid_ff && rsp_valid_ff))
      else $error("request lost while response stalled");

   a_response_follows_request: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("no response after accepted request");

endmodule

// ----- design/bbcd_core.sv -----
module bbcd_core (
   input logic clock,
   input logic reset,
   input logic accept,
   input bbcd_pkg::req_type req,
   input bbcd_pkg::cfg_type cfg,
   input logic period_load,
   output logic busy,
   output bbcd_pkg::rsp_type result
);

   localparam int CB = bbcd_pkg::CFG_BITS;
   localparam int SB = bbcd_pkg::SAMPLE_BITS;
   localparam logic [$clog2(CB)-1:0] DIV_LAST = $clog2(CB)'(CB - 1);

   logic laser_on_ff, laser_on_in;
   logic running_ff, running_in;
   logic calibrated_ff, calibrated_in;
   logic in_cal_ff, in_cal_in;
   logic [CB-1:0] count_ff, count_in;
   logic [CB-1:0] phase_ff, phase_in;
   logic [SB-1:0] dark_min_ff, dark_min_in;
   logic dark_valid_ff, dark_valid_in;
   logic [SB-1:0] lit_max_ff, lit_max_in;
   logic lit_valid_ff, lit_valid_in;
   logic div_busy_ff, div_busy_in;
   logic [$clog2(CB)-1:0] div_step_ff, div_step_in;
   logic [CB-1:0] div_rem_ff, div_rem_in;

   logic [CB-1:0] count_inc;
   logic [CB:0] phase_inc;
   logic phase_wrap;
   logic [CB-1:0] phase_step;
   logic [CB:0] div_trial;
   logic [CB:0] div_diff;
   logic [CB-1:0] div_next;
   logic cut, inconc;
   bbcd_pkg::status_type status;

   assign count_inc = count_ff + CB'(1);
   assign phase_inc = {1'b0, phase_ff} + (CB+1)'(1);
   assign phase_wrap = (phase_inc == {1'b0, cfg.toggle_period});
   assign phase_step = phase_wrap ? '0 : phase_inc[CB-1:0];

   // one remainder bit per cycle after a toggle period write
   assign div_trial = {div_rem_ff, count_ff[div_step_ff]};
   assign div_diff = div_trial - {1'b0, cfg.toggle_period};
   assign div_next = (div_trial >= {1'b0, cfg.toggle_period}) ? div_diff[CB-1:0]
                                                               : div_trial[CB-1:0];

   always_comb begin
      laser_on_in = laser_on_ff;
      running_in = running_ff;
      calibrated_in = calibrated_ff;
      in_cal_in = in_cal_ff;
      count_in = count_ff;
      phase_in = phase_ff;
      dark_min_in = dark_min_ff;
      dark_valid_in = dark_valid_ff;
      lit_max_in = lit_max_ff;
      lit_valid_in = lit_valid_ff;
      div_busy_in = div_busy_ff;
      div_step_in = div_step_ff;
      div_rem_in = div_rem_ff;
      cut = 1'b0;
      inconc = 1'b0;
      status = bbcd_pkg::STATUS_OK;

      if (period_load) begin
         div_busy_in = 1'b1;
         div_step_in = DIV_LAST;
         div_rem_in = '0;
      end else if (div_busy_ff) begin
         div_rem_in = div_next;
         if (div_step_ff == '0) begin
            div_busy_in = 1'b0;
            phase_in = div_next;
         end else begin
            div_step_in = div_step_ff - $clog2(CB)'(1);
         end
      end

      if (accept) begin
         if (req.kind == bbcd_pkg::KIND_START) begin
            calibrated_in = 1'b0;
            in_cal_in = 1'b1;
            count_in = '0;
            phase_in = '0;
            laser_on_in = !laser_on_ff;
         end else if (in_cal_ff) begin
            if (req.kind == bbcd_pkg::KIND_CHECK) begin
               if (laser_on_ff) begin
                  if (!lit_valid_ff || lit_max_ff < req.sample) begin
                     lit_max_in = req.sample;
                     lit_valid_in = 1'b1;
                  end
               end else begin
                  if (!dark_valid_ff || dark_min_ff > req.sample) begin
                     dark_min_in = req.sample;
                     dark_valid_in = 1'b1;
                  end
               end
               count_in = count_inc;
               phase_in = phase_step;
               if (count_inc >= cfg.calibration_length) begin
                  in_cal_in = 1'b0;
                  calibrated_in = 1'b1;
                  running_in = cfg.stay_on;
                  laser_on_in = cfg.stay_on;
               end else if (cfg.toggle_period != '0 && phase_wrap) begin
                  laser_on_in = !laser_on_ff;
               end
            end else begin
               status = bbcd_pkg::STATUS_BUSY;
            end
         end else if (req.kind == bbcd_pkg::KIND_RUN) begin
            if (!calibrated_ff) begin
               status = bbcd_pkg::STATUS_NOT_CALIBRATED;
            end else begin
               laser_on_in = 1'b1;
               running_in = 1'b1;
            end
         end else if (req.kind == bbcd_pkg::KIND_STOP) begin
            if (running_ff) begin
               laser_on_in = 1'b0;
               running_in = 1'b0;
            end
         end else begin
            if (!running_ff) begin
               status = bbcd_pkg::STATUS_NOT_RUNNING;
            end else if (!calibrated_ff) begin
               status = bbcd_pkg::STATUS_NOT_CALIBRATED;
            end else if (!dark_valid_ff || req.sample > dark_min_ff) begin
               cut = 1'b1;
            end else if (lit_valid_ff && req.sample < lit_max_ff) begin
               cut = 1'b0;
            end else begin
               inconc = 1'b1;
            end
         end
      end
   end

   always_comb begin
      result.laser_drive = laser_on_in;
      result.running = running_in;
      result.calibrated = calibrated_in && !in_cal_in;
      result.calibrating = in_cal_in;
      result.beam_cut = cut;
      result.inconclusive = inconc;
      result.status = status;
   end

   assign busy = div_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         laser_on_ff <= 1'b0;
         running_ff <= 1'b0;
         calibrated_ff <= 1'b0;
         in_cal_ff <= 1'b0;
         count_ff <= '0;
         phase_ff <= '0;
         dark_valid_ff <= 1'b0;
         lit_valid_ff <= 1'b0;
         div_busy_ff <= 1'b0;
         div_step_ff <= '0;
      end else begin
         laser_on_ff <= laser_on_in;
         running_ff <= running_in;
         calibrated_ff <= calibrated_in;
         in_cal_ff <= in_cal_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
         dark_valid_ff <= dark_valid_in;
         lit_valid_ff <= lit_valid_in;
         div_busy_ff <= div_busy_in;
         div_step_ff <= div_step_in;
      end
   end

   always_ff @(posedge clock) begin
      dark_min_ff <= dark_min_in;
      lit_max_ff <= lit_max_in;
      div_rem_ff <= div_rem_in;
   end

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> !accept)
      else $error("request accepted during remainder update");

   a_phase_in_range: assert property (@(posedge clock) disable iff (reset)
      (!div_busy_ff && cfg.toggle_period != '0) |-> (phase_ff < cfg.toggle_period))
      else $error("toggle phase out of range");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req.kind == bbcd_pkg::KIND_START) |=>
         (in_cal_ff && count_ff == '0 && phase_ff == '0 && !calibrated_ff))
      else $error("start did not open calibration");

   a_calibration_end: assert property (@(posedge clock) disable iff (reset)
      $rose(calibrated_ff) |-> $fell(in_cal_ff))
      else $error("calibrated set outside calibration end");

endmodule

// ----- tb/sv/beam_barrier_calibrate_detect_tb.sv -----
module beam_barrier_calibrate_detect_tb;
   import bbcd_pkg::*;

   localparam int HOLD_CYCLES = 150;
   localparam int QUIET_LIMIT = 1000;
   localparam int PHASE_ITEMS = 160;

   typedef struct packed {
      kind_type kind;
      logic [SAMPLE_BITS-1:0] sample;
      logic typed;
      rsp_type want;
   } step_type;

   // want flags: laser running calibrated calibrating cut inconclusive
   localparam step_type STEPS [25] = '{
      '{KIND_CHECK, 10'd0, 1'b1, {6'b000000, STATUS_NOT_RUNNING}},
      '{KIND_RUN, 10'd1023, 1'b1, {6'b000000, STATUS_NOT_CALIBRATED}},
      '{KIND_STOP, 10'd5, 1'b1, {6'b000000, STATUS_OK}},
      '{KIND_START, 10'd0, 1'b1, {6'b100100, STATUS_OK}},
      '{KIND_START, 10'd1023, 1'b1, {6'b000100, STATUS_OK}},
      '{KIND_RUN, 10'd0, 1'b1, {6'b000100, STATUS_BUSY}},
      '{KIND_STOP, 10'd0, 1'b1, {6'b000100, STATUS_BUSY}},
      '{KIND_CHECK, 10'd600, 1'b0, 8'h00},
      '{KIND_CHECK, 10'd1023, 1'b0, 8'h00},
      '{KIND_CHECK, 10'd700, 1'b0, 8'h00},
      '{KIND_CHECK, 10'd1023, 1'b0, 8'h00},
      '{KIND_CHECK, 10'd600, 1'b0, 8'h00},
      '{KIND_CHECK, 10'd0, 1'b0, 8'h00},
      '{KIND_STOP, 10'd0, 1'b0, 8'h00},
      '{KIND_CHECK, 10'd300, 1'b0, 8'h00},
      '{KIND_RUN, 10'd0, 1'b0, 8'h00},
      '{KIND_START, 10'd0, 1'b0, 8'h00},
      '{KIND_START, 10'd0, 1'b0, 8'h00},
      '{KIND_CHECK, 10'd0, 1'b0, 8'h00},
      '{KIND_CHECK, 10'd200, 1'b0, 8'h00},
      '{KIND_CHECK, 10'd100, 1'b0, 8'h00},
      '{KIND_CHECK, 10'd601, 1'b0, 8'h00},
      '{KIND_CHECK, 10'd199, 1'b0, 8'h00},
      '{KIND_CHECK, 10'd400, 1'b0, 8'h00},
      '{KIND_CHECK, 10'd200, 1'b0, 8'h00}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   logic [CFG_BITS-1:0] cfg_length = CALIBRATION_LENGTH_RESET;
   logic [CFG_BITS-1:0] cfg_period = TOGGLE_PERIOD_RESET;
   logic cfg_stay = STAY_ON_RESET;

   logic laser_on = 1'b0;
   logic barrier_running = 1'b0;
   logic barrier_calibrated = 1'b0;
   logic calibrating_now = 1'b0;
   logic [CFG_BITS-1:0] cal_count = '0;
   logic [SAMPLE_BITS-1:0] dark_min = '0;
   logic dark_min_ok = 1'b0;
   logic [SAMPLE_BITS-1:0] lit_max = '0;
   logic lit_max_ok = 1'b0;

   rsp_type results_due[$];
   int items_sent = 0;
   int results_seen = 0;
   int mismatches = 0;
   int sender_idle_pct = 24;
   int receiver_idle_pct = 76;
   int holds_asked = 0;
   int holds_started = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   beam_barrier_calibrate_detect dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   function automatic void flag_error(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s", msg);
      end
   endfunction

   function automatic rsp_type advance_barrier(input kind_type kind,
                                               input logic [SAMPLE_BITS-1:0] sample);
      rsp_type res;
      res = '0;
      if (kind == KIND_START) begin
         barrier_calibrated = 1'b0;
         calibrating_now = 1'b1;
         cal_count = '0;
         laser_on = !laser_on;
      end else if (calibrating_now) begin
         if (kind == KIND_CHECK) begin
            if (laser_on) begin
               if (!lit_max_ok || lit_max < sample) begin
                  lit_max = sample;
                  lit_max_ok = 1'b1;
               end
            end else if (!dark_min_ok || dark_min > sample) begin
               dark_min = sample;
               dark_min_ok = 1'b1;
            end
            cal_count = cal_count + 7'd1;
            if (cal_count >= cfg_length) begin
               calibrating_now = 1'b0;
               barrier_calibrated = 1'b1;
               barrier_running = cfg_stay;
               laser_on = cfg_stay;
            end else if (cfg_period != '0 && cal_count % cfg_period == '0) begin
               laser_on = !laser_on;
            end
         end else begin
            res.status = STATUS_BUSY;
         end
      end else if (kind == KIND_RUN) begin
         if (!barrier_calibrated) begin
            res.status = STATUS_NOT_CALIBRATED;
         end else begin
            laser_on = 1'b1;
            barrier_running = 1'b1;
         end
      end else if (kind == KIND_STOP) begin
         if (barrier_running) begin
            laser_on = 1'b0;
            barrier_running = 1'b0;
         end
      end else if (!barrier_running) begin
         res.status = STATUS_NOT_RUNNING;
      end else if (!barrier_calibrated) begin
         res.status = STATUS_NOT_CALIBRATED;
      end else if (!dark_min_ok || sample > dark_min) begin
         res.beam_cut = 1'b1;
      end else if (!(lit_max_ok && sample < lit_max)) begin
         res.inconclusive = 1'b1;
      end
      res.laser_drive = laser_on;
      res.running = barrier_running;
      res.calibrated = barrier_calibrated && !calibrating_now;
      res.calibrating = calibrating_now;
      return res;
   endfunction

   task automatic drive_request(input kind_type kind, input logic [SAMPLE_BITS-1:0] sample,
                                input logic typed = 1'b0, input rsp_type want = '0);
      rsp_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {kind, sample};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = advance_barrier(kind, sample);
      results_due.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [REG_SEL_BITS-1:0] sel,
                                 input logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] stored;
      stored = '0;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {sel, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (sel)
         REG_CALIBRATION_LENGTH: begin
            cfg_length = value[CFG_BITS-1:0];
            stored = CSR_DATA_BITS'(cfg_length);
         end
         REG_TOGGLE_PERIOD: begin
            cfg_period = value[CFG_BITS-1:0];
            stored = CSR_DATA_BITS'(cfg_period);
         end
         REG_STAY_ON: begin
            cfg_stay = value[0];
            stored = CSR_DATA_BITS'(cfg_stay);
         end
         default: begin
         end
      endcase
      // read back
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== stored) begin
         flag_error($sformatf("register %0d read back %h, expected %h", sel, csr_prdata, stored));
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // receiver: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_started != holds_asked) begin
         holds_started <= holds_started + 1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // outputs only move at rising edges, so the falling edge sees what the next edge accepts
   always @(negedge clock) begin
      rsp_type want;
      string diffs;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (results_due.size() == 0) begin
            flag_error($sformatf("result %0d arrived with nothing expected: %b",
                                 results_seen, rsp_data));
         end else begin
            want = results_due.pop_front();
            diffs = "";
            if (rsp_data.laser_drive !== want.laser_drive) diffs = {diffs, " laser_drive"};
            if (rsp_data.running !== want.running) diffs = {diffs, " running"};
            if (rsp_data.calibrated !== want.calibrated) diffs = {diffs, " calibrated"};
            if (rsp_data.calibrating !== want.calibrating) diffs = {diffs, " calibrating"};
            if (rsp_data.beam_cut !== want.beam_cut) diffs = {diffs, " beam_cut"};
            if (rsp_data.inconclusive !== want.inconclusive) diffs = {diffs, " inconclusive"};
            if (rsp_data.status !== want.status) diffs = {diffs, " status"};
            if (diffs != "") begin
               flag_error($sformatf("result %0d differs in%s: expected %b got %b",
                                    results_seen, diffs, want, rsp_data));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("beam_barrier_calibrate_detect_tb failed");
         $finish;
      end
   end

   initial begin
      int phase;
      int phase_end;
      int n;
      int i;
      logic [CSR_DATA_BITS-1:0] new_len;
      logic [CSR_DATA_BITS-1:0] new_per;
      logic [CSR_DATA_BITS-1:0] new_stay;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_register(REG_CALIBRATION_LENGTH, 32'd3);
      write_register(REG_TOGGLE_PERIOD, 32'd0);
      write_register(REG_STAY_ON, 32'd1);
      for (i = 0; i < $size(STEPS); i++) begin
         drive_request(STEPS[i].kind, STEPS[i].sample, STEPS[i].typed, STEPS[i].want);
      end

      for (phase = 0; phase < 6; phase++) begin
         drain_results();
         case (phase)
            0: begin new_len = 32'd5; new_per = 32'd2; new_stay = 32'd1; end
            1: begin new_len = 32'd0; new_per = 32'd1; new_stay = 32'd0; end
            2: begin new_len = 32'd127; new_per = 32'd127; new_stay = 32'd1; end
            3: begin new_len = 32'd1; new_per = 32'd0; new_stay = 32'd1; end
            4: begin new_len = 32'd8; new_per = 32'd3; new_stay = 32'd0; end
            default: begin
               new_len = $urandom_range(127);
               new_per = $urandom_range(127);
               new_stay = $urandom_range(1);
            end
         endcase
         write_register(REG_CALIBRATION_LENGTH, new_len);
         write_register(REG_TOGGLE_PERIOD, new_per);
         write_register(REG_STAY_ON, new_stay);
         sender_idle_pct = (phase < 2) ? 24 : (phase < 4) ? 76 : 0;
         receiver_idle_pct = (phase < 2) ? 76 : (phase < 4) ? 24 : 0;
         if (phase == 4) begin
            holds_asked++;
         end
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            if ($urandom_range(9) < 7) begin
               drive_request(KIND_START, SAMPLE_BITS'($urandom_range(1023)));
               n = (cfg_length == '0) ? 1 : int'(cfg_length);
               // sometimes cut short so later items land mid-calibration
               if ($urandom_range(9) == 0) begin
                  n = $urandom_range(n);
               end
               for (i = 0; i < n; i++) begin
                  if ($urandom_range(29) == 0) begin
                     drive_request(kind_type'($urandom_range(3, 2)),
                                   SAMPLE_BITS'($urandom_range(1023)));
                  end
                  // lit readings low, dark readings high so checks reach all outcomes
                  drive_request(KIND_CHECK, ($urandom_range(99) == 0) ?
                                SAMPLE_BITS'($urandom_range(1023)) : laser_on ?
                                SAMPLE_BITS'($urandom_range(350)) :
                                SAMPLE_BITS'($urandom_range(1023, 650)));
               end
               repeat ($urandom_range(10, 2)) begin
                  case ($urandom_range(7))
                     0: drive_request(KIND_STOP, SAMPLE_BITS'($urandom_range(1023)));
                     1: drive_request(KIND_RUN, SAMPLE_BITS'($urandom_range(1023)));
                     default: drive_request(KIND_CHECK, SAMPLE_BITS'($urandom_range(1023)));
                  endcase
               end
            end else begin
               repeat ($urandom_range(4, 1)) begin
                  drive_request(kind_type'($urandom_range(3)), SAMPLE_BITS'($urandom_range(1023)));
               end
            end
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("beam_barrier_calibrate_detect_tb passed");
      end else begin
         $display("beam_barrier_calibrate_detect_tb failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/bbcd_pkg.sv
design/bbcd_core.sv
design/beam_barrier_calibrate_detect.sv
tb/sv/beam_barrier_calibrate_detect_tb.sv
